### hdl/tgcf_pkg.sv
// Shared types, constants and register codes for the threshold gate cluster finder.
`default_nettype none
package tgcf_pkg;

	// Fixed field widths of the sample and cluster words.
	localparam int AMP_W     = 24;
	localparam int MULT_W    = 8;
	localparam int CHG_W     = 40;
	localparam int IDX_W     = 20;
	localparam int CNT_W     = 16;
	localparam int THR_W     = 24;
	localparam int GATE_W    = 13;
	localparam int LB_W      = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 24;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 152;

	// Defaults for the top-level parameters.
	localparam int DEF_LOOKBACK_DEPTH = 64;
	localparam int DEF_MAX_GATE       = 4096;
	localparam int DEF_MAX_RECORD     = 1048576;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GATE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOKBACK  = 2'd2;

	// One cluster word as it leaves the block.
	typedef struct packed {
		logic [OUT_DATA_W-1:0] data;
		logic                  trunc;
	} tgcf_word_t;

	// Control states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_TRIG = 3'b100
	} tgcf_state_t;

	// Saturating add of one amplitude to the charge accumulator.
	function automatic logic signed [CHG_W-1:0] sat_add(
		input logic signed [CHG_W-1:0] acc,
		input logic signed [AMP_W-1:0] amp
	);
		logic signed [CHG_W:0] s;
		s = {acc[CHG_W-1], acc} + {{(CHG_W+1-AMP_W){amp[AMP_W-1]}}, amp};
		if (s[CHG_W] != s[CHG_W-1])
			sat_add = s[CHG_W] ? {1'b1, {(CHG_W-1){1'b0}}} : {1'b0, {(CHG_W-1){1'b1}}};
		else
			sat_add = s[CHG_W-1:0];
	endfunction

endpackage
`default_nettype wire

### hdl/tgcf_hist_mem.sv
// History ring memory: one write port, one registered read port.
`default_nettype none
module tgcf_hist_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### hdl/tgcf_out.sv
// Output register with one skid word for cluster words.
`default_nettype none
module tgcf_out (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire tgcf_pkg::tgcf_word_t word,
	output logic                    busy,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [tgcf_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                    m_tuser
);
	import tgcf_pkg::*;

	logic       out_v_q;
	tgcf_word_t out_q;
	logic       pend_v_q;
	tgcf_word_t pend_q;
	logic       free;

	assign free     = !out_v_q || m_tready;
	assign busy     = pend_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q.data;
	assign m_tuser  = out_q.trunc;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (free) begin
				out_v_q <= pend_v_q || load;
			end
			if (pend_v_q && free) begin
				pend_v_q <= 1'b0;
			end else if (load && !free) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	// Payload: the skid word goes out first, a new word waits there if the port is busy.
	always_ff @(posedge clk) begin
		if (free) begin
			out_q <= pend_v_q ? pend_q : word;
		end
		if (load && !free) begin
			pend_q <= word;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !pend_v_q) else $error("cluster word loaded over a waiting word");
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && m_tready) |=> !pend_v_q) else $error("skid word not drained");
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid) else $error("cluster word dropped while stalled");

endmodule
`default_nettype wire

### hdl/threshold_gate_cluster_finder.sv
// Top level of the threshold gate cluster finder.
//
//  channel | direction | handshake          | contents
//  s_*     | in        | s_tvalid/s_tready  | one waveform sample word
//  m_*     | out       | m_tvalid/m_tready  | one cluster word
//  cfg_*   | in        | cfg_we             | register write
//
// A sample that does not trigger is handled as it is accepted. A trigger with no lookback
// goes on to the trigger state. Otherwise the history ring, which has one read port, is
// walked one sample a cycle: b = min(sample index, lookback, gate) reads, then the last
// read drains and the walk closes. The cluster word is emitted there when the gate ends
// inside the history; otherwise the trigger sample is integrated in the trigger state.
// Reset clears all control state; the history ring holds no reset value.
// A stalled output is absorbed by one skid word; input is taken only when idle and it is empty.
`default_nettype none
module threshold_gate_cluster_finder #(
	parameter int LOOKBACK_DEPTH = tgcf_pkg::DEF_LOOKBACK_DEPTH,
	parameter int MAX_GATE       = tgcf_pkg::DEF_MAX_GATE,
	parameter int MAX_RECORD     = tgcf_pkg::DEF_MAX_RECORD
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// amplitude [23:0], multiplicity [31:24]
	input  wire logic [tgcf_pkg::IN_DATA_W-1:0] s_tdata,
	input  wire logic s_tlast,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// cluster_number [15:0], start_index [35:16], end_index [55:36],
	// charge_sum [95:56], peak_index [115:96], peak_height [139:116],
	// largest multiplicity [147:140], zeros [151:148]
	output logic [tgcf_pkg::OUT_DATA_W-1:0] m_tdata,
	// truncated [0]
	output logic      m_tuser,
	input  wire logic cfg_we,
	input  wire logic [tgcf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tgcf_pkg::CFG_DAT_W-1:0] cfg_data
);
	import tgcf_pkg::*;

	localparam int AW = (LOOKBACK_DEPTH > 1) ? $clog2(LOOKBACK_DEPTH) : 1;
	localparam int KW = $clog2(LOOKBACK_DEPTH + 1);
	localparam int GW = $clog2(MAX_GATE + 1);
	localparam int NW = $clog2(MAX_RECORD);

	// Configuration registers.
	logic signed [THR_W-1:0] thr_q;
	logic [GATE_W-1:0]       gate_q;
	logic [LB_W-1:0]         lb_q;

	// Cluster state.
	tgcf_state_t             state_q;
	logic [AW-1:0]           ptr_q;
	logic [NW-1:0]           n_q;
	logic                    open_q;
	logic [GW-1:0]           grem_q;
	logic [GW-1:0]           gclip_q;
	logic signed [CHG_W-1:0] chg_q;
	logic signed [AMP_W-1:0] pk_q;
	logic [NW-1:0]           pkpos_q;
	logic [MULT_W-1:0]       mmax_q;
	logic [NW-1:0]           start_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    seen_q;
	logic [KW-1:0]           k_q;
	logic signed [AMP_W-1:0] hamp_q;
	logic [MULT_W-1:0]       hmult_q;
	logic                    hfin_q;
	logic                    rd_v_s1;
	logic [NW-1:0]           rd_idx_s1;

	// Input word fields.
	logic signed [AMP_W-1:0] in_amp;
	logic [MULT_W-1:0]       in_mult;
	logic                    in_fin;
	logic                    s_fire;
	logic                    trig;

	assign in_amp  = s_tdata[AMP_W-1:0];
	assign in_mult = s_tdata[AMP_W+MULT_W-1:AMP_W];
	assign in_fin  = s_tlast || (n_q >= NW'(MAX_RECORD - 1));
	assign s_fire  = s_tvalid && s_tready;
	assign trig    = !open_q && (in_amp >= thr_q);

	// Gate and lookback limits as seen at a trigger.
	logic [31:0]   g32, lb32, back32;
	logic [GW-1:0] gclip;
	logic [KW-1:0] back;

	always_comb begin
		if (gate_q == '0)
			g32 = 32'd1;
		else if (32'(gate_q) > MAX_GATE)
			g32 = MAX_GATE;
		else
			g32 = 32'(gate_q);
		lb32   = (32'(lb_q) > LOOKBACK_DEPTH) ? LOOKBACK_DEPTH : 32'(lb_q);
		back32 = (32'(n_q) < lb32) ? 32'(n_q) : lb32;
		gclip  = g32[GW-1:0];
		back   = back32[KW-1:0];
	end

	// History ring read address and issue control for the lookback walk.
	logic [31:0]             slot32;
	logic [AW-1:0]           raddr;
	logic                    issue;
	logic                    walk_done;
	logic [AMP_W+MULT_W-1:0] rdata;
	logic signed [AMP_W-1:0] rd_amp;
	logic [MULT_W-1:0]       rd_mult;

	always_comb begin
		slot32 = 32'(ptr_q) + LOOKBACK_DEPTH - 32'(k_q);
		if (slot32 >= LOOKBACK_DEPTH)
			slot32 = slot32 - LOOKBACK_DEPTH;
		raddr = slot32[AW-1:0];
	end

	assign issue     = (state_q == ST_WALK) && (k_q != '0) && (grem_q != '0);
	assign walk_done = (state_q == ST_WALK) && !issue && !rd_v_s1;
	assign rd_amp    = rdata[AMP_W-1:0];
	assign rd_mult   = rdata[AMP_W+MULT_W-1:AMP_W];

	// Sample that closes the current item: the live input when idle, the held one otherwise.
	// A walk that leaves gate samples over hands the item on to the trigger cycle.
	logic signed [AMP_W-1:0] cur_amp;
	logic [MULT_W-1:0]       cur_mult;
	logic                    cur_fin;
	logic                    finish;

	always_comb begin
		cur_amp  = (state_q == ST_IDLE) ? in_amp : hamp_q;
		cur_mult = (state_q == ST_IDLE) ? in_mult : hmult_q;
		cur_fin  = (state_q == ST_IDLE) ? in_fin : hfin_q;
		finish   = (s_fire && !trig) || (state_q == ST_TRIG) ||
			(walk_done && grem_q == '0);
	end

	// Integration of one sample into an open cluster.
	logic                    apply;
	logic signed [CHG_W-1:0] ap_chg;
	logic [GW-1:0]           ap_grem;
	logic                    do_trk;
	logic signed [AMP_W-1:0] ap_pk;
	logic [NW-1:0]           ap_pkpos;
	logic [MULT_W-1:0]       ap_mm;
	logic                    ap_emit;

	always_comb begin
		apply    = (s_fire && !trig && open_q) || (state_q == ST_TRIG);
		ap_chg   = sat_add(chg_q, cur_amp);
		ap_grem  = (grem_q != '0) ? grem_q - GW'(1) : '0;
		do_trk   = !cur_fin || !seen_q;
		ap_pk    = pk_q;
		ap_pkpos = pkpos_q;
		ap_mm    = mmax_q;
		if (do_trk && (!seen_q || cur_amp > pk_q)) begin
			ap_pk    = cur_amp;
			ap_pkpos = n_q;
		end
		if (do_trk && (!seen_q || cur_mult > mmax_q))
			ap_mm = cur_mult;
		ap_emit = cur_fin || (ap_grem == '0);
	end

	// Cluster word assembly.
	logic       emit_v;
	logic [31:0] end32;
	tgcf_word_t emit_word;
	logic       out_busy;

	always_comb begin
		emit_v = (apply && ap_emit) || (walk_done && grem_q == '0);
		if (walk_done)
			end32 = 32'(start_q) + 32'(gclip_q);
		else if (cur_fin)
			end32 = 32'(n_q);
		else
			end32 = 32'(n_q) + 32'd1;
		emit_word.data = '0;
		emit_word.data[15:0]    = cnt_q;
		emit_word.data[35:16]   = IDX_W'(start_q);
		emit_word.data[55:36]   = end32[IDX_W-1:0];
		emit_word.data[95:56]   = walk_done ? chg_q : ap_chg;
		emit_word.data[115:96]  = IDX_W'(walk_done ? pkpos_q : ap_pkpos);
		emit_word.data[139:116] = walk_done ? pk_q : ap_pk;
		emit_word.data[147:140] = walk_done ? mmax_q : ap_mm;
		emit_word.trunc = !walk_done && cur_fin;
	end

	assign s_tready = (state_q == ST_IDLE) && !out_busy;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			gate_q <= GATE_W'(1);
			lb_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: thr_q  <= cfg_data[THR_W-1:0];
				CFG_GATE:      gate_q <= cfg_data[GATE_W-1:0];
				CFG_LOOKBACK:  lb_q   <= cfg_data[LB_W-1:0];
				default:       ;
			endcase
		end
	end

	// Held trigger sample and walk read tags.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			hamp_q  <= in_amp;
			hmult_q <= in_mult;
			hfin_q  <= in_fin;
		end
		if (issue)
			rd_idx_s1 <= n_q - NW'(k_q);
	end

	// Control and accumulation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
			n_q     <= '0;
			open_q  <= 1'b0;
			grem_q  <= '0;
			gclip_q <= '0;
			chg_q   <= '0;
			pk_q    <= {1'b1, {(AMP_W-1){1'b0}}};
			pkpos_q <= '0;
			mmax_q  <= '0;
			start_q <= '0;
			cnt_q   <= '0;
			seen_q  <= 1'b0;
			k_q     <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;

			// A trigger opens a cluster and starts the lookback walk, or with no lookback the trigger state.
			if (s_fire && trig) begin
				open_q  <= 1'b1;
				start_q <= n_q - NW'(back);
				grem_q  <= gclip;
				gclip_q <= gclip;
				chg_q   <= '0;
				pk_q    <= {1'b1, {(AMP_W-1){1'b0}}};
				pkpos_q <= '0;
				mmax_q  <= '0;
				seen_q  <= 1'b0;
				k_q     <= back;
				state_q <= (back != '0) ? ST_WALK : ST_TRIG;
			end

			// Walk: one history read issued per cycle, data integrated in the cycle after.
			if (issue) begin
				k_q    <= k_q - KW'(1);
				grem_q <= grem_q - GW'(1);
			end
			if (rd_v_s1) begin
				chg_q  <= sat_add(chg_q, rd_amp);
				seen_q <= 1'b1;
				if (!seen_q || rd_amp > pk_q) begin
					pk_q    <= rd_amp;
					pkpos_q <= rd_idx_s1;
				end
				if (!seen_q || rd_mult > mmax_q)
					mmax_q <= rd_mult;
			end
			if (walk_done)
				state_q <= (grem_q == '0) ? ST_IDLE : ST_TRIG;
			if (state_q == ST_TRIG)
				state_q <= ST_IDLE;

			// Integrate the closing sample of an open cluster.
			if (apply) begin
				chg_q   <= ap_chg;
				grem_q  <= ap_grem;
				pk_q    <= ap_pk;
				pkpos_q <= ap_pkpos;
				mmax_q  <= ap_mm;
				seen_q  <= seen_q || do_trk;
			end

			// A cluster word closes the cluster.
			if (emit_v) begin
				cnt_q  <= cnt_q + CNT_W'(1);
				open_q <= 1'b0;
				grem_q <= '0;
			end

			// Item done: ring pointer and sample index advance.
			if (finish) begin
				ptr_q <= (32'(ptr_q) == LOOKBACK_DEPTH - 1) ? '0 : ptr_q + AW'(1);
				if (cur_fin) begin
					n_q    <= '0;
					cnt_q  <= '0;
					open_q <= 1'b0;
					grem_q <= '0;
				end else begin
					n_q <= n_q + NW'(1);
				end
			end
		end
	end

	tgcf_hist_mem #(
		.DEPTH (LOOKBACK_DEPTH),
		.AW    (AW),
		.DW    (AMP_W + MULT_W)
	) u_hist (
		.clk   (clk),
		.we    (finish),
		.waddr (ptr_q),
		.wdata ({cur_mult, cur_amp}),
		.re    (issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	tgcf_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (emit_v),
		.word     (emit_word),
		.busy     (out_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_rd_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == ST_WALK)) else $error("history read outside walk");
	a_walk_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> open_q) else $error("walk without open cluster");
	a_gate_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (32'(grem_q) <= MAX_GATE)) else $error("gate count out of range");
	a_trig_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRIG) |=> (state_q == ST_IDLE)) else $error("trigger sample stuck");

endmodule
`default_nettype wire

### test/threshold_gate_cluster_finder_tb.sv
// Testbench for the threshold gate cluster finder: directed and random samples checked against a cluster predictor.
`default_nettype none
module threshold_gate_cluster_finder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tgcf_pkg::*;

	localparam int RING     = 64;
	localparam int GATE_CAP = 4096;
	localparam int REC_CAP  = 1048576;
	localparam int WDOG     = 20000;

	typedef struct packed {
		logic [15:0]        number;
		logic [19:0]        first_idx;
		logic [19:0]        last_idx;
		logic signed [39:0] charge;
		logic [19:0]        peak_idx;
		logic signed [23:0] peak;
		logic [7:0]         mult;
		logic               trunc;
	} cluster_t;

	// Predicts cluster words from accepted samples and checks the block output.
	class cluster_board;
		logic signed [23:0] thr;
		int unsigned gate, lookback;
		logic signed [23:0] amp_ring [RING];
		logic [7:0]  mult_ring [RING];
		int unsigned wr_ptr, sample_no, gate_left, first_idx, peak_idx, count;
		bit open, seen;
		logic signed [39:0] charge;
		logic signed [23:0] peak;
		logic [7:0] mmax;
		cluster_t pending [$];
		int errors;

		function new();
			thr = 0; gate = 1; lookback = 0; wr_ptr = 0; sample_no = 0;
			open = 0; gate_left = 0; count = 0; errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [23:0] val);
			case (idx)
				CFG_THRESHOLD: thr = val;
				CFG_GATE:      gate = val[12:0];
				CFG_LOOKBACK:  lookback = val[6:0];
				default: ;
			endcase
		endfunction

		function void add_amp(logic signed [23:0] a);
			logic signed [40:0] s;
			s = 41'(charge) + 41'(a);
			if (s > 41'sd549755813887) s = 41'sd549755813887;
			if (s < -41'sd549755813888) s = -41'sd549755813888;
			charge = s[39:0];
		endfunction

		function void track(logic signed [23:0] a, logic [7:0] m, int unsigned idx);
			if (!seen || a > peak) begin
				peak = a;
				peak_idx = idx;
			end
			if (!seen || m > mmax) mmax = m;
			seen = 1;
		endfunction

		function void close(int unsigned last, bit tr);
			cluster_t c;
			c.number = count[15:0];
			c.first_idx = first_idx[19:0];
			c.last_idx = last[19:0];
			c.charge = charge;
			c.peak_idx = peak_idx[19:0];
			c.peak = peak;
			c.mult = mmax;
			c.trunc = tr;
			pending = {pending, c};
			count = (count + 1) & 16'hffff;
			open = 0;
			gate_left = 0;
		endfunction

		function void body(logic signed [23:0] a, logic [7:0] m, int unsigned n, bit fin);
			if (fin) begin
				if (!seen) track(a, m, n);
				close(n, 1);
			end else begin
				track(a, m, n);
				if (gate_left == 0) close(n + 1, 0);
			end
		endfunction

		function void note_sample(logic signed [23:0] a, logic [7:0] m, bit last);
			int unsigned n, lb, g, back, slot;
			bit fin;
			n = sample_no;
			fin = last || (n >= REC_CAP - 1);
			if (!open && a >= thr) begin
				lb = (lookback > RING) ? RING : lookback;
				g = (gate == 0) ? 1 : ((gate > GATE_CAP) ? GATE_CAP : gate);
				back = (n < lb) ? n : lb;
				open = 1; first_idx = n - back; gate_left = g;
				charge = 0; peak = -24'sd8388608; peak_idx = 0; mmax = 0; seen = 0;
				for (int k = back; k >= 1 && gate_left > 0; k--) begin
					slot = (wr_ptr + RING - k) % RING;
					add_amp(amp_ring[slot]);
					track(amp_ring[slot], mult_ring[slot], n - k);
					gate_left--;
				end
				if (gate_left == 0) close(first_idx + g, 0);
				else begin
					add_amp(a);
					gate_left--;
					body(a, m, n, fin);
				end
			end else if (open) begin
				add_amp(a);
				if (gate_left > 0) gate_left--;
				body(a, m, n, fin);
			end
			amp_ring[wr_ptr] = a;
			mult_ring[wr_ptr] = m;
			wr_ptr = (wr_ptr + 1) % RING;
			if (fin) begin
				sample_no = 0; count = 0; open = 0; gate_left = 0;
			end else sample_no = n + 1;
		endfunction

		function void check_word(logic [151:0] d, logic u);
			cluster_t e, g;
			g = {d[15:0], d[35:16], d[55:36], d[95:56], d[115:96], d[139:116],
				d[147:140], u};
			if (pending.size() == 0) begin
				$error("unexpected cluster word %h", d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (g.number != e.number) begin
				$error("cluster_number exp %0d got %0d", e.number, g.number); errors++;
			end
			if (g.first_idx != e.first_idx) begin
				$error("start_index exp %0d got %0d", e.first_idx, g.first_idx); errors++;
			end
			if (g.last_idx != e.last_idx) begin
				$error("end_index exp %0d got %0d", e.last_idx, g.last_idx); errors++;
			end
			if (g.charge != e.charge) begin
				$error("charge_sum exp %0d got %0d", e.charge, g.charge); errors++;
			end
			if (g.peak_idx != e.peak_idx) begin
				$error("peak_index exp %0d got %0d", e.peak_idx, g.peak_idx); errors++;
			end
			if (g.peak != e.peak) begin
				$error("peak_height exp %0d got %0d", e.peak, g.peak); errors++;
			end
			if (g.mult != e.mult) begin
				$error("peak_mult exp %0d got %0d", e.mult, g.mult); errors++;
			end
			if (g.trunc != e.trunc) begin
				$error("truncated exp %0d got %0d", e.trunc, g.trunc); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tlast;
	logic [31:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser;
	logic [151:0] m_tdata;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [23:0] cfg_data;

	cluster_board board;
	int idle_cycles;
	int unsigned rx_cyc;

	threshold_gate_cluster_finder u_top (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Sample the output side and count cycles with no word moving.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) board.check_word(m_tdata, m_tuser);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver stalls in a pattern of its own, with calm stretches.
	always @(posedge clk) begin
		int p;
		p = $urandom_range(0, 99);
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_cyc <= 0;
		end else begin
			rx_cyc <= rx_cyc + 1;
			if ((rx_cyc / 64) % 3 == 0) m_tready <= 1'b1;
			else m_tready <= (p < 65);
		end
	end

	always @(posedge clk) begin
		if (idle_cycles > WDOG) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		board.set_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every expected cluster, then let any lookback walk finish.
	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic send_sample(logic signed [23:0] a, logic [7:0] m, bit last);
		s_tvalid <= 1'b1;
		s_tdata <= {m, a};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_sample(a, m, last);
	endtask

	task automatic gap();
		if ($urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// A record: quiet baseline with pulses above threshold, then an end mark.
	task automatic send_record(int unsigned len, logic signed [23:0] thr);
		logic signed [23:0] a;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 9))
				0: a = thr + $urandom_range(0, 1000);
				1: a = $urandom();
				2: a = {1'b0, {23{1'b1}}};
				3: a = {1'b1, 23'd0};
				default: a = thr - $urandom_range(1, 2000);
			endcase
			send_sample(a, $urandom(), (i == len - 1));
			gap();
		end
	endtask

	initial begin
		logic signed [23:0] t;
		board = new();
		arst_n = 0;
		s_tvalid = 0; s_tdata = 0; s_tlast = 0;
		cfg_we = 0; cfg_index = CFG_THRESHOLD; cfg_data = 0;
		idle_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes with the reset settings, then a short lookback gate.
		send_sample(-24'sd8388608, 8'd0, 0);
		send_sample(24'sd8388607, 8'd255, 0);
		send_sample(24'sd0, 8'd1, 0);
		send_sample(-24'sd1, 8'd2, 1);
		s_tvalid <= 1'b0;
		drain();
		write_reg(CFG_THRESHOLD, 24'd100);
		write_reg(CFG_GATE, 24'd8);
		write_reg(CFG_LOOKBACK, 24'd3);
		// Trigger near sample 0 so lookback is clipped, then end inside the gate.
		send_sample(24'sd5, 8'd9, 0);
		send_sample(24'sd200, 8'd3, 0);
		send_sample(24'sd200, 8'd7, 0);
		send_sample(24'sd50, 8'd1, 1);
		// End on the trigger sample itself.
		send_sample(24'sd300, 8'd4, 1);
		// Gate shorter than lookback, and a zero gate.
		send_sample(24'sd1, 8'd1, 0);
		s_tvalid <= 1'b0;
		drain();
		write_reg(CFG_GATE, 24'd2);
		write_reg(CFG_LOOKBACK, 24'd127);
		for (int i = 0; i < 6; i++) send_sample(24'sd10 * i, 8'(i), 0);
		send_sample(24'sd500, 8'd8, 0);
		send_sample(24'sd0, 8'd0, 1);
		s_tvalid <= 1'b0;
		drain();
		write_reg(CFG_GATE, 24'd0);
		send_sample(24'sd500, 8'd8, 0);
		send_sample(24'sd600, 8'd9, 1);
		s_tvalid <= 1'b0;
		drain();

		// Random phases with varied settings, the extremes among them.
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: t = -24'sd8388608;
				1: t = 24'sd8388607;
				default: t = $urandom_range(0, 4000) - 2000;
			endcase
			write_reg(CFG_THRESHOLD, t);
			write_reg(CFG_GATE, (ph == 2) ? 24'd8191 : (ph == 3 ? 24'd4096 :
				$urandom_range(1, 40)));
			write_reg(CFG_LOOKBACK, (ph == 4) ? 24'd64 : $urandom_range(0, 20));
			for (int r = 0; r < 5; r++) send_record($urandom_range(5, 40), t);
			s_tvalid <= 1'b0;
			drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
hdl/tgcf_pkg.sv
hdl/tgcf_hist_mem.sv
hdl/tgcf_out.sv
hdl/threshold_gate_cluster_finder.sv
test/threshold_gate_cluster_finder_tb.sv
